// ----- rtl/pressure_projection_solver_assert.svh -----
// assertion macros shared by the solver rtl
`ifndef PRESSURE_PROJECTION_SOLVER_ASSERT_SVH
`define PRESSURE_PROJECTION_SOLVER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PPS_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pps assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PPS_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pps assertion failed");

`endif

// ----- rtl/pps_pkg.sv -----
// shared constants and saturation helpers for the pressure projection solver
`timescale 1ns / 1ps
package pps_pkg;

  localparam int OP_W   = 2;
  localparam int VEL_W  = 16;
  localparam int PRS_W  = 24;
  localparam int ACC_W  = 28;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int CNT_W  = 8;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_SOLVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CNT_W-1:0] SWEEP_RESET = 8'd40;

  typedef logic signed [ACC_W-1:0] acc_t;

  // clamp to signed 24 bit
  function automatic logic [PRS_W-1:0] sat24(input acc_t v);
    if (v > 28'sd8388607) begin
      return 24'h7FFFFF;
    end else if (v < -28'sd8388608) begin
      return 24'h800000;
    end else begin
      return v[PRS_W-1:0];
    end
  endfunction

  // clamp to signed 16 bit
  function automatic logic [VEL_W-1:0] sat16(input acc_t v);
    if (v > 28'sd32767) begin
      return 16'h7FFF;
    end else if (v < -28'sd32768) begin
      return 16'h8000;
    end else begin
      return v[VEL_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/pps_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module pps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pressure_projection_solver.sv -----
// pressure projection solver top level: command decode, solve sequencer, state memories
//
//   channel   signals                                         direction
//   request   start, busy, in_op, in_cell_x/y, in_vx, in_vy   in
//   result    out_valid, out_reply_kind, out_vx/vy/pressure  out
//   config    cfg_valid, cfg_ready, cfg_data (sweep_count)    in
//
// load and read may follow back to back; a result appears in the cycle after
// its request is taken. solve holds busy until its result; each memory has a
// single read port. a solve clears the whole pressure memory after its
// divergence pass; before the first solve pressure reads return zero.
// synchronous active-low reset.
// results cannot be stalled; each strobe lasts one cycle.
`timescale 1ns / 1ps
`include "pressure_projection_solver_assert.svh"
module pressure_projection_solver #(
  parameter int GRID_W = 128,
  parameter int GRID_H = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pps_pkg::OP_W-1:0]       in_op,
  input  logic [pps_pkg::COL_W-1:0]      in_cell_x,
  input  logic [pps_pkg::ROW_W-1:0]      in_cell_y,
  input  logic signed [pps_pkg::VEL_W-1:0] in_vx,
  input  logic signed [pps_pkg::VEL_W-1:0] in_vy,
  output logic                           out_valid,
  output logic [pps_pkg::OP_W-1:0]       out_reply_kind,
  output logic signed [pps_pkg::VEL_W-1:0] out_vx,
  output logic signed [pps_pkg::VEL_W-1:0] out_vy,
  output logic signed [pps_pkg::PRS_W-1:0] out_pressure,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pps_pkg::CNT_W-1:0]      cfg_data
);

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(GRID_W);
  localparam int RW = $clog2(GRID_H);
  localparam int IW = (CW > RW) ? CW : RW;
  localparam int VW = pps_pkg::VEL_W;
  localparam int PW = pps_pkg::PRS_W;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_DIV   = 3'd1;
  localparam logic [2:0] PH_CLR   = 3'd2;
  localparam logic [2:0] PH_SWP   = 3'd3;
  localparam logic [2:0] PH_PWALL = 3'd4;
  localparam logic [2:0] PH_VEL   = 3'd5;
  localparam logic [2:0] PH_VWALL = 3'd6;

  localparam logic [2:0] SEG_L = 3'd0;
  localparam logic [2:0] SEG_R = 3'd1;
  localparam logic [2:0] SEG_T = 3'd2;
  localparam logic [2:0] SEG_B = 3'd3;
  localparam logic [2:0] SEG_C = 3'd4;

  localparam logic [CW-1:0] C_ONE  = CW'(1);
  localparam logic [CW-1:0] C_LAST = CW'(GRID_W - 1);
  localparam logic [CW-1:0] C_IN   = CW'(GRID_W - 2);
  localparam logic [RW-1:0] R_ONE  = RW'(1);
  localparam logic [RW-1:0] R_LAST = RW'(GRID_H - 1);
  localparam logic [RW-1:0] R_IN   = RW'(GRID_H - 2);

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
    return AW'(c) * AW'(GRID_H) + AW'(r);
  endfunction

  logic [2:0]              phase_r, phase_nxt;
  logic [2:0]              sub_r, sub_nxt;
  logic [CW-1:0]           c_r, c_nxt;
  logic [RW-1:0]           r_r, r_nxt;
  logic [2:0]              wseg_r, wseg_nxt;
  logic [IW-1:0]           wi_r, wi_nxt;
  logic [pps_pkg::CNT_W-1:0] k_r, k_nxt;
  pps_pkg::acc_t           acc_r, acc_nxt, acc2_r, acc2_nxt;
  logic [VW-1:0]           vxh_r, vxh_nxt, vyh_r, vyh_nxt;
  logic [pps_pkg::CNT_W-1:0] sweep_r;
  logic                    p_init_r, p_init_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [pps_pkg::OP_W-1:0] out_kind_r, out_kind_nxt;
  logic                    out_rd_r, out_rd_nxt;

  logic          vx_we, vy_we, p_we, d_we;
  logic [AW-1:0] wa, vx_ra, vy_ra, p_ra, d_ra;
  logic [VW-1:0] vx_wd, vy_wd, vx_rd, vy_rd;
  logic [PW-1:0] p_wd, d_wd, p_rd, d_rd;

  pps_pkg::acc_t vx_s, vy_s, p_s, d_s, sum_s, gx_s, gy_s;
  logic          in_grid;
  logic [AW-1:0] in_addr, own_a;
  logic          last_cell, last_full, wall_edge_done;
  logic [CW-1:0] nc_c;
  logic [RW-1:0] nc_r;
  logic [CW-1:0] src_c, dst_c, b_c;
  logic [RW-1:0] src_r, dst_r, b_r;
  logic          neg_lr;

  // state memories
  pps_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_vx (
    .clk(clk), .we(vx_we), .waddr(wa), .wdata(vx_wd), .raddr(vx_ra), .rdata(vx_rd));
  pps_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_vy (
    .clk(clk), .we(vy_we), .waddr(wa), .wdata(vy_wd), .raddr(vy_ra), .rdata(vy_rd));
  pps_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_p (
    .clk(clk), .we(p_we), .waddr(wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  pps_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_d (
    .clk(clk), .we(d_we), .waddr(wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));

  // widened read data
  assign vx_s = pps_pkg::acc_t'($signed(vx_rd));
  assign vy_s = pps_pkg::acc_t'($signed(vy_rd));
  assign p_s  = pps_pkg::acc_t'($signed(p_rd));
  assign d_s  = pps_pkg::acc_t'($signed(d_rd));

  // request decode
  assign in_grid = (32'(in_cell_x) < GRID_W) && (32'(in_cell_y) < GRID_H);
  assign in_addr = cell_addr(CW'(in_cell_x), RW'(in_cell_y));
  assign own_a   = cell_addr(c_r, r_r);

  // interior walk, column outer, row inner
  assign last_cell = (c_r == C_IN) && (r_r == R_IN);
  assign last_full = (c_r == C_LAST) && (r_r == R_LAST);
  assign nc_r = (r_r == R_IN) ? R_ONE : r_r + R_ONE;
  assign nc_c = (r_r == R_IN) ? c_r + C_ONE : c_r;

  // wall geometry: source, destination and second corner neighbor
  always_comb begin
    src_c = '0;
    src_r = '0;
    dst_c = '0;
    dst_r = '0;
    b_c = '0;
    b_r = '0;
    case (wseg_r)
      SEG_L: begin
        src_c = C_ONE;  src_r = RW'(wi_r); dst_c = '0;     dst_r = RW'(wi_r);
      end
      SEG_R: begin
        src_c = C_IN;   src_r = RW'(wi_r); dst_c = C_LAST; dst_r = RW'(wi_r);
      end
      SEG_T: begin
        src_c = CW'(wi_r); src_r = R_ONE;  dst_c = CW'(wi_r); dst_r = '0;
      end
      SEG_B: begin
        src_c = CW'(wi_r); src_r = R_IN;   dst_c = CW'(wi_r); dst_r = R_LAST;
      end
      default: begin
        case (wi_r[1:0])
          2'd0: begin
            dst_c = '0;     dst_r = '0;     src_c = C_ONE; src_r = '0;
            b_c = '0;       b_r = R_ONE;
          end
          2'd1: begin
            dst_c = '0;     dst_r = R_LAST; src_c = C_ONE; src_r = R_LAST;
            b_c = '0;       b_r = R_IN;
          end
          2'd2: begin
            dst_c = C_LAST; dst_r = '0;     src_c = C_IN;  src_r = '0;
            b_c = C_LAST;   b_r = R_ONE;
          end
          default: begin
            dst_c = C_LAST; dst_r = R_LAST; src_c = C_IN;  src_r = R_LAST;
            b_c = C_LAST;   b_r = R_IN;
          end
        endcase
      end
    endcase
  end

  assign neg_lr = (wseg_r == SEG_L) || (wseg_r == SEG_R);
  assign wall_edge_done = (neg_lr && (wi_r == IW'(GRID_H - 2)))
                       || (!neg_lr && (wi_r == IW'(GRID_W - 2)));

  // stencil sums
  assign sum_s = acc_r + p_s;
  assign gx_s  = (acc_r + 28'sd16) >>> 5;
  assign gy_s  = (acc2_r + 28'sd16) >>> 5;

  // sequencer
  always_comb begin
    phase_nxt = phase_r;
    sub_nxt = sub_r;
    c_nxt = c_r;
    r_nxt = r_r;
    wseg_nxt = wseg_r;
    wi_nxt = wi_r;
    k_nxt = k_r;
    acc_nxt = acc_r;
    acc2_nxt = acc2_r;
    vxh_nxt = vxh_r;
    vyh_nxt = vyh_r;
    p_init_nxt = p_init_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt = out_kind_r;
    out_rd_nxt = 1'b0;
    vx_we = 1'b0;
    vy_we = 1'b0;
    p_we = 1'b0;
    d_we = 1'b0;
    wa = own_a;
    vx_wd = '0;
    vy_wd = '0;
    p_wd = '0;
    d_wd = '0;
    vx_ra = own_a;
    vy_ra = own_a;
    p_ra = own_a;
    d_ra = own_a;
    case (phase_r)
      PH_IDLE: begin
        vx_ra = in_addr;
        vy_ra = in_addr;
        p_ra = in_addr;
        wa = in_addr;
        if (start) begin
          out_kind_nxt = in_op;
          if (in_op == pps_pkg::OP_SOLVE) begin
            phase_nxt = PH_DIV;
            sub_nxt = '0;
            c_nxt = C_ONE;
            r_nxt = R_ONE;
            p_init_nxt = 1'b1;
          end else begin
            out_valid_nxt = 1'b1;
            if (in_op == pps_pkg::OP_LOAD) begin
              vx_we = in_grid;
              vy_we = in_grid;
              vx_wd = in_vx;
              vy_wd = in_vy;
            end else if (in_op == pps_pkg::OP_READ) begin
              out_rd_nxt = in_grid;
            end
          end
        end
      end
      // divergence: sum of the central differences times eight, scaled to Q8.15
      PH_DIV: begin
        case (sub_r)
          3'd0: begin
            vx_ra = cell_addr(c_r + C_ONE, r_r);
            vy_ra = cell_addr(c_r, r_r + R_ONE);
            sub_nxt = 3'd1;
          end
          3'd1: begin
            acc_nxt = vx_s + vy_s;
            vx_ra = cell_addr(c_r - C_ONE, r_r);
            vy_ra = cell_addr(c_r, r_r - R_ONE);
            sub_nxt = 3'd2;
          end
          default: begin
            d_we = 1'b1;
            d_wd = pps_pkg::sat24((acc_r - vx_s - vy_s) <<< 3);
            sub_nxt = '0;
            c_nxt = nc_c;
            r_nxt = nc_r;
            if (last_cell) begin
              phase_nxt = PH_CLR;
              c_nxt = '0;
              r_nxt = '0;
            end
          end
        endcase
      end
      // zero the whole pressure memory
      PH_CLR: begin
        p_we = 1'b1;
        r_nxt = (r_r == R_LAST) ? '0 : r_r + R_ONE;
        c_nxt = (r_r == R_LAST) ? c_r + C_ONE : c_r;
        if (last_full) begin
          c_nxt = C_ONE;
          r_nxt = R_ONE;
          sub_nxt = '0;
          k_nxt = '0;
          phase_nxt = (sweep_r == '0) ? PH_VEL : PH_SWP;
        end
      end
      // one in-place relaxation sweep, one cell at a time
      PH_SWP: begin
        case (sub_r)
          3'd0: begin
            p_ra = cell_addr(c_r - C_ONE, r_r);
            sub_nxt = 3'd1;
          end
          3'd1: begin
            acc_nxt = p_s - d_s;
            p_ra = cell_addr(c_r + C_ONE, r_r);
            sub_nxt = 3'd2;
          end
          3'd2: begin
            acc_nxt = sum_s;
            p_ra = cell_addr(c_r, r_r - R_ONE);
            sub_nxt = 3'd3;
          end
          3'd3: begin
            acc_nxt = sum_s;
            p_ra = cell_addr(c_r, r_r + R_ONE);
            sub_nxt = 3'd4;
          end
          default: begin
            p_we = 1'b1;
            p_wd = pps_pkg::sat24((sum_s + 28'sd2) >>> 2);
            sub_nxt = '0;
            c_nxt = nc_c;
            r_nxt = nc_r;
            if (last_cell) begin
              phase_nxt = PH_PWALL;
              wseg_nxt = SEG_L;
              wi_nxt = IW'(1);
            end
          end
        endcase
      end
      // pressure walls: edges copy, corners average
      PH_PWALL: begin
        p_ra = cell_addr(src_c, src_r);
        wa = cell_addr(dst_c, dst_r);
        if (wseg_r != SEG_C) begin
          if (sub_r == '0) begin
            sub_nxt = 3'd1;
          end else begin
            p_we = 1'b1;
            p_wd = p_rd;
            sub_nxt = '0;
            wi_nxt = wi_r + IW'(1);
            if (wall_edge_done) begin
              wseg_nxt = wseg_r + 3'd1;
              wi_nxt = (wseg_r == SEG_B) ? '0 : IW'(1);
            end
          end
        end else begin
          case (sub_r)
            3'd0: sub_nxt = 3'd1;
            3'd1: begin
              acc_nxt = p_s;
              p_ra = cell_addr(b_c, b_r);
              sub_nxt = 3'd2;
            end
            default: begin
              p_we = 1'b1;
              p_wd = PW'((acc_r + p_s + 28'sd1) >>> 1);
              sub_nxt = '0;
              wi_nxt = wi_r + IW'(1);
              if (wi_r[1:0] == 2'd3) begin
                k_nxt = k_r + 8'd1;
                c_nxt = C_ONE;
                r_nxt = R_ONE;
                phase_nxt = (k_r + 8'd1 == sweep_r) ? PH_VEL : PH_SWP;
              end
            end
          endcase
        end
      end
      // subtract half the pressure gradient
      PH_VEL: begin
        case (sub_r)
          3'd0: begin
            p_ra = cell_addr(c_r + C_ONE, r_r);
            sub_nxt = 3'd1;
          end
          3'd1: begin
            acc_nxt = p_s;
            p_ra = cell_addr(c_r - C_ONE, r_r);
            sub_nxt = 3'd2;
          end
          3'd2: begin
            acc_nxt = acc_r - p_s;
            p_ra = cell_addr(c_r, r_r + R_ONE);
            sub_nxt = 3'd3;
          end
          3'd3: begin
            acc2_nxt = p_s;
            p_ra = cell_addr(c_r, r_r - R_ONE);
            sub_nxt = 3'd4;
          end
          3'd4: begin
            acc2_nxt = acc2_r - p_s;
            vxh_nxt = vx_rd;
            vyh_nxt = vy_rd;
            sub_nxt = 3'd5;
          end
          default: begin
            vx_we = 1'b1;
            vy_we = 1'b1;
            vx_wd = pps_pkg::sat16(pps_pkg::acc_t'($signed(vxh_r)) - gx_s);
            vy_wd = pps_pkg::sat16(pps_pkg::acc_t'($signed(vyh_r)) - gy_s);
            sub_nxt = '0;
            c_nxt = nc_c;
            r_nxt = nc_r;
            if (last_cell) begin
              phase_nxt = PH_VWALL;
              wseg_nxt = SEG_L;
              wi_nxt = IW'(1);
            end
          end
        endcase
      end
      // velocity walls: normal negated, tangential copied, corners averaged
      PH_VWALL: begin
        vx_ra = cell_addr(src_c, src_r);
        vy_ra = cell_addr(src_c, src_r);
        wa = cell_addr(dst_c, dst_r);
        if (wseg_r != SEG_C) begin
          if (sub_r == '0) begin
            sub_nxt = 3'd1;
          end else begin
            vx_we = 1'b1;
            vy_we = 1'b1;
            vx_wd = neg_lr ? pps_pkg::sat16(-vx_s) : vx_rd;
            vy_wd = neg_lr ? vy_rd : pps_pkg::sat16(-vy_s);
            sub_nxt = '0;
            wi_nxt = wi_r + IW'(1);
            if (wall_edge_done) begin
              wseg_nxt = wseg_r + 3'd1;
              wi_nxt = (wseg_r == SEG_B) ? '0 : IW'(1);
            end
          end
        end else begin
          case (sub_r)
            3'd0: sub_nxt = 3'd1;
            3'd1: begin
              acc_nxt = vx_s;
              acc2_nxt = vy_s;
              vx_ra = cell_addr(b_c, b_r);
              vy_ra = cell_addr(b_c, b_r);
              sub_nxt = 3'd2;
            end
            default: begin
              vx_we = 1'b1;
              vy_we = 1'b1;
              vx_wd = VW'((acc_r + vx_s + 28'sd1) >>> 1);
              vy_wd = VW'((acc2_r + vy_s + 28'sd1) >>> 1);
              sub_nxt = '0;
              wi_nxt = wi_r + IW'(1);
              if (wi_r[1:0] == 2'd3) begin
                phase_nxt = PH_IDLE;
                out_valid_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sub_r <= '0;
      p_init_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_rd_r <= 1'b0;
      sweep_r <= pps_pkg::SWEEP_RESET;
    end else begin
      phase_r <= phase_nxt;
      sub_r <= sub_nxt;
      p_init_r <= p_init_nxt;
      out_valid_r <= out_valid_nxt;
      out_rd_r <= out_rd_nxt;
      if (cfg_valid && cfg_ready) begin
        sweep_r <= cfg_data;
      end
    end
  end

  // walk counters and datapath holds
  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    r_r <= r_nxt;
    wseg_r <= wseg_nxt;
    wi_r <= wi_nxt;
    k_r <= k_nxt;
    acc_r <= acc_nxt;
    acc2_r <= acc2_nxt;
    vxh_r <= vxh_nxt;
    vyh_r <= vyh_nxt;
    out_kind_r <= out_kind_nxt;
  end

  // ports
  assign busy = (phase_r != PH_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_reply_kind = out_kind_r;
  assign out_vx = out_rd_r ? vx_rd : '0;
  assign out_vy = out_rd_r ? vy_rd : '0;
  assign out_pressure = (out_rd_r && p_init_r) ? p_rd : '0;

  `PPS_ASSERT_NEXT(a_read_reply, start && !busy && in_op == pps_pkg::OP_READ,
                   out_valid && out_reply_kind == pps_pkg::OP_READ)
  `PPS_ASSERT_IMPL(a_idle_no_pwrite, !busy, !p_we)
  `PPS_ASSERT_IMPL(a_solve_reply, out_valid && out_reply_kind == pps_pkg::OP_SOLVE, $past(busy))

endmodule

// ----- bench/tb.sv -----
// self-checking testbench for the pressure projection solver
`timescale 1ns / 1ps
module tb;

  localparam int W = 128;
  localparam int H = 64;
  localparam int CELLS = W * H;
  localparam logic [pps_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 800000;
  localparam int DIR_ROWS = 16;

  typedef struct packed {
    logic [pps_pkg::OP_W-1:0]         kind;
    logic signed [pps_pkg::VEL_W-1:0] vx;
    logic signed [pps_pkg::VEL_W-1:0] vy;
    logic signed [pps_pkg::PRS_W-1:0] p;
  } reply_t;

  typedef struct {
    logic [pps_pkg::OP_W-1:0] op;
    int               x;
    int               y;
    int               vx;
    int               vy;
    bit               typed;
    int               evx;
    int               evy;
    int               ep;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [pps_pkg::OP_W-1:0] in_op = '0;
  logic [pps_pkg::COL_W-1:0] in_cell_x = '0;
  logic [pps_pkg::ROW_W-1:0] in_cell_y = '0;
  logic signed [pps_pkg::VEL_W-1:0] in_vx = '0;
  logic signed [pps_pkg::VEL_W-1:0] in_vy = '0;
  logic out_valid;
  logic [pps_pkg::OP_W-1:0] out_reply_kind;
  logic signed [pps_pkg::VEL_W-1:0] out_vx;
  logic signed [pps_pkg::VEL_W-1:0] out_vy;
  logic signed [pps_pkg::PRS_W-1:0] out_pressure;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pps_pkg::CNT_W-1:0] cfg_data = '0;

  // predictor state
  int fld_vx[CELLS];
  int fld_vy[CELLS];
  int fld_p[CELLS];
  int fld_div[CELLS];
  int sweeps;

  reply_t pending_replies[$];
  int errors = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;
  stim_row_t dir_tab[DIR_ROWS];

  always #10 clk = ~clk;

  pressure_projection_solver #(.GRID_W(W), .GRID_H(H)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_cell_x(in_cell_x), .in_cell_y(in_cell_y),
    .in_vx(in_vx), .in_vy(in_vy),
    .out_valid(out_valid), .out_reply_kind(out_reply_kind),
    .out_vx(out_vx), .out_vy(out_vy), .out_pressure(out_pressure),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic int at(int c, int r);
    return c * H + r;
  endfunction

  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic int clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return int'(hi);
    if (v < -hi - 1) return int'(-hi - 1);
    return int'(v);
  endfunction

  function automatic int wall_val(int v, bit neg);
    return neg ? clamp(-longint'(v), 16) : v;
  endfunction

  // edges copy or negate the inner neighbor, then corners average
  function automatic void apply_walls(ref int a[CELLS], input bit neg_lr, input bit neg_tb);
    for (int r = 1; r < H - 1; r++) begin
      a[at(0, r)] = wall_val(a[at(1, r)], neg_lr);
      a[at(W - 1, r)] = wall_val(a[at(W - 2, r)], neg_lr);
    end
    for (int c = 1; c < W - 1; c++) begin
      a[at(c, 0)] = wall_val(a[at(c, 1)], neg_tb);
      a[at(c, H - 1)] = wall_val(a[at(c, H - 2)], neg_tb);
    end
    a[at(0, 0)] = int'(rnd_shift(longint'(a[at(1, 0)]) + a[at(0, 1)], 1));
    a[at(0, H - 1)] = int'(rnd_shift(longint'(a[at(1, H - 1)]) + a[at(0, H - 2)], 1));
    a[at(W - 1, 0)] = int'(rnd_shift(longint'(a[at(W - 2, 0)]) + a[at(W - 1, 1)], 1));
    a[at(W - 1, H - 1)] =
      int'(rnd_shift(longint'(a[at(W - 2, H - 1)]) + a[at(W - 1, H - 2)], 1));
  endfunction

  // divergence, relaxation sweeps with pressure walls, gradient subtraction, velocity walls
  function automatic void run_projection();
    longint s;
    longint gx;
    longint gy;
    for (int c = 1; c < W - 1; c++)
      for (int r = 1; r < H - 1; r++) begin
        s = longint'(fld_vx[at(c + 1, r)]) - fld_vx[at(c - 1, r)]
          + fld_vy[at(c, r + 1)] - fld_vy[at(c, r - 1)];
        fld_div[at(c, r)] = clamp(s * 8, 24);
      end
    for (int i = 0; i < CELLS; i++) fld_p[i] = 0;
    for (int k = 0; k < sweeps; k++) begin
      for (int c = 1; c < W - 1; c++)
        for (int r = 1; r < H - 1; r++) begin
          s = longint'(fld_p[at(c - 1, r)]) + fld_p[at(c + 1, r)]
            + fld_p[at(c, r - 1)] + fld_p[at(c, r + 1)] - fld_div[at(c, r)];
          fld_p[at(c, r)] = clamp(rnd_shift(s, 2), 24);
        end
      apply_walls(fld_p, 1'b0, 1'b0);
    end
    for (int c = 1; c < W - 1; c++)
      for (int r = 1; r < H - 1; r++) begin
        gx = longint'(fld_p[at(c + 1, r)]) - fld_p[at(c - 1, r)];
        gy = longint'(fld_p[at(c, r + 1)]) - fld_p[at(c, r - 1)];
        fld_vx[at(c, r)] = clamp(longint'(fld_vx[at(c, r)]) - rnd_shift(gx, 5), 16);
        fld_vy[at(c, r)] = clamp(longint'(fld_vy[at(c, r)]) - rnd_shift(gy, 5), 16);
      end
    apply_walls(fld_vx, 1'b1, 1'b0);
    apply_walls(fld_vy, 1'b0, 1'b1);
  endfunction

  function automatic reply_t predict_reply(logic [pps_pkg::OP_W-1:0] op, int x, int y,
                                           int vx, int vy);
    reply_t rep;
    rep = '0;
    rep.kind = op;
    if (op == pps_pkg::OP_LOAD) begin
      fld_vx[at(x, y)] = vx;
      fld_vy[at(x, y)] = vy;
    end else if (op == pps_pkg::OP_SOLVE) begin
      run_projection();
    end else if (op == pps_pkg::OP_READ) begin
      rep.vx = fld_vx[at(x, y)][pps_pkg::VEL_W-1:0];
      rep.vy = fld_vy[at(x, y)][pps_pkg::VEL_W-1:0];
      rep.p = fld_p[at(x, y)][pps_pkg::PRS_W-1:0];
    end
    return rep;
  endfunction

  // drive one request and hold it until taken
  task automatic send_request(logic [pps_pkg::OP_W-1:0] op, int x, int y, int vx, int vy,
                              bit typed, reply_t typed_rep);
    reply_t rep;
    start <= 1'b1;
    in_op <= op;
    in_cell_x <= x[pps_pkg::COL_W-1:0];
    in_cell_y <= y[pps_pkg::ROW_W-1:0];
    in_vx <= vx[pps_pkg::VEL_W-1:0];
    in_vy <= vy[pps_pkg::VEL_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    rep = predict_reply(op, x, y, $signed(vx[pps_pkg::VEL_W-1:0]),
                        $signed(vy[pps_pkg::VEL_W-1:0]));
    pending_replies.push_back(typed ? typed_rep : rep);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // hold off until all replies are in, then let the block settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sweeps(int value);
    cfg_valid <= 1'b1;
    cfg_data <= value[pps_pkg::CNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sweeps = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_vel();
    case ($urandom_range(0, 7))
      0: return $signed(16'($urandom()));
      1: return 32767;
      2: return -32768;
      default: return $urandom_range(0, 4096) - 2048;
    endcase
  endfunction

  // one random request, never a solve
  task automatic random_request();
    int pick;
    reply_t none;
    none = '0;
    pick = $urandom_range(0, 15);
    if (pick == 0)
      send_request(OP_UNUSED, $urandom_range(0, W - 1), $urandom_range(0, H - 1),
                   $urandom(), $urandom(), 1'b0, none);
    else if (pick < 8)
      send_request(pps_pkg::OP_LOAD, $urandom_range(0, W - 1), $urandom_range(0, H - 1),
                   rand_vel(), rand_vel(), 1'b0, none);
    else
      send_request(pps_pkg::OP_READ, $urandom_range(0, W - 1), $urandom_range(0, H - 1),
                   $urandom(), $urandom(), 1'b0, none);
  endtask

  // result checker
  always @(posedge clk) begin
    reply_t exp_rep;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result kind %0d", out_reply_kind);
      end else begin
        exp_rep = pending_replies.pop_front();
        if (out_reply_kind !== exp_rep.kind || out_vx !== exp_rep.vx ||
            out_vy !== exp_rep.vy || out_pressure !== exp_rep.p) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp kind %0d vx %0d vy %0d p %0d, got %0d %0d %0d %0d",
                     exp_rep.kind, exp_rep.vx, exp_rep.vy, exp_rep.p,
                     out_reply_kind, out_vx, out_vy, out_pressure);
        end
      end
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int phase_sweeps[4];
    reply_t tr;
    phase_sweeps = '{0, 1, 2, 1};
    sweeps = pps_pkg::SWEEP_RESET;
    for (int i = 0; i < CELLS; i++) begin
      fld_vx[i] = 0;
      fld_vy[i] = 0;
      fld_p[i] = 0;
      fld_div[i] = 0;
    end
    // directed rows: extremes, corners, unused op
    dir_tab = '{
      '{pps_pkg::OP_LOAD,   0,  0,  32767, -32768, 1'b1, 0, 0, 0},
      '{pps_pkg::OP_READ,   0,  0,      0,      0, 1'b1, 32767, -32768, 0},
      '{pps_pkg::OP_LOAD, 127, 63, -32768,  32767, 1'b1, 0, 0, 0},
      '{pps_pkg::OP_READ, 127, 63,     -1,     -1, 1'b1, -32768, 32767, 0},
      '{pps_pkg::OP_LOAD, 127,  0,     -1,      1, 1'b1, 0, 0, 0},
      '{pps_pkg::OP_READ, 127,  0,      0,      0, 1'b1, -1, 1, 0},
      '{pps_pkg::OP_LOAD,   0, 63,      0,      0, 1'b1, 0, 0, 0},
      '{pps_pkg::OP_READ,   0, 63,  32767,  32767, 1'b1, 0, 0, 0},
      '{OP_UNUSED,        127, 63,     -1,     -1, 1'b1, 0, 0, 0},
      '{OP_UNUSED,          0,  0,      0,      0, 1'b1, 0, 0, 0},
      '{pps_pkg::OP_LOAD,  64, 32,  21845, -21846, 1'b0, 0, 0, 0},
      '{pps_pkg::OP_READ,  64, 32,      0,      0, 1'b0, 0, 0, 0},
      '{pps_pkg::OP_LOAD,  64, 32, -21846,  21845, 1'b0, 0, 0, 0},
      '{pps_pkg::OP_READ,  64, 32,      0,      0, 1'b0, 0, 0, 0},
      '{pps_pkg::OP_READ, 127, 63,      0,      0, 1'b0, 0, 0, 0},
      '{pps_pkg::OP_READ,   0,  0,      0,      0, 1'b0, 0, 0, 0}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset sweep count
    for (int i = 0; i < DIR_ROWS; i++) begin
      tr.kind = dir_tab[i].op;
      tr.vx = dir_tab[i].evx[pps_pkg::VEL_W-1:0];
      tr.vy = dir_tab[i].evy[pps_pkg::VEL_W-1:0];
      tr.p = dir_tab[i].ep[pps_pkg::PRS_W-1:0];
      send_request(dir_tab[i].op, dir_tab[i].x, dir_tab[i].y, dir_tab[i].vx,
                   dir_tab[i].vy, dir_tab[i].typed, tr);
    end
    drain();
    write_sweeps(255);

    // fill every cell so a solve never touches an unwritten entry
    tr = '0;
    for (int c = 0; c < W; c++)
      for (int r = 0; r < H; r++)
        send_request(pps_pkg::OP_LOAD, c, r, rand_vel(), rand_vel(), 1'b0, tr);

    // random phases, each closed by a solve at its own sweep count
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_sweeps(phase_sweeps[ph]);
      for (int i = 0; i < 120; i++) random_request();
      send_request(pps_pkg::OP_SOLVE, $urandom_range(0, W - 1), $urandom_range(0, H - 1),
                   $urandom(), $urandom(), 1'b0, tr);
    end
    for (int i = 0; i < 30; i++) random_request();

    // last stretch back to back at the top and reset counts
    drain();
    write_sweeps(255);
    quiet = 1'b1;
    for (int i = 0; i < 30; i++) random_request();
    drain();
    write_sweeps(pps_pkg::SWEEP_RESET);
    for (int i = 0; i < 20; i++) random_request();
    start <= 1'b0;

    @(posedge clk);
    while (pending_replies.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
